// ----- src/pvs_pkg.sv -----
// Shared types, sizes and codes of the palette voxel store.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pvs_pkg;

    // Volume and palette dimensions.
    localparam int MAX_DIM       = 32;
    localparam int PALETTE_DEPTH = 256;

    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int VOX_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int VOX_AW    = $clog2(VOX_DEPTH);
    localparam int PAL_AW    = $clog2(PALETTE_DEPTH);
    localparam int PAL_CW    = PAL_AW + 1;

    // Fixed field widths.
    localparam int COORD_W   = 6;
    localparam int SIZE_W    = 6;
    localparam int COLOR_W   = 32;
    localparam int ALPHA_W   = 8;
    localparam int COUNT_W   = 16;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int SIZE_RESET = 32;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 80;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_TAKE  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    typedef struct packed {
        logic              valid;
        logic              inrange;
        logic [VOX_AW-1:0] flat;
    } addr_rsp_t;

    typedef struct packed {
        logic               lookup;
        logic               fetch;
        logic [COLOR_W-1:0] color;
        logic [PAL_AW-1:0]  index;
    } pal_cmd_t;

    typedef struct packed {
        logic               done;
        logic               full;
        logic [PAL_AW-1:0]  idx;
        logic [COLOR_W-1:0] color;
    } pal_rsp_t;

    typedef struct packed {
        logic             valid;
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] z;
    } mark_t;

    // Bounds order from index 0: min x, max x, min y, max y, min z, max z.
    typedef struct packed {
        logic [5:0][DIM_W-1:0] bounds;
        logic                  full;
        logic                  empty;
    } region_t;

endpackage

// ----- src/pvs_addr_gen.sv -----
// Two-stage flat voxel address generator with range check.
// Depends on pvs_pkg.
`timescale 1ns / 1ps

module pvs_addr_gen (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pvs_pkg::COORD_W-1:0] pos_x,
    input  logic [pvs_pkg::COORD_W-1:0] pos_y,
    input  logic [pvs_pkg::COORD_W-1:0] pos_z,
    input  logic [pvs_pkg::SIZE_W-1:0]  size_x,
    input  logic [pvs_pkg::SIZE_W-1:0]  size_y,
    input  logic [pvs_pkg::SIZE_W-1:0]  size_z,
    output pvs_pkg::addr_rsp_t          rsp
);
    import pvs_pkg::*;

    localparam int PROD_W = 2 * SIZE_W;
    localparam int SUM_W  = COORD_W + PROD_W;
    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_DIM);

    logic [SIZE_W-1:0]  sx, sy, sz;
    logic               v1_reg, inr1_reg;
    logic [COORD_W-1:0] px1_reg, pz1_reg;
    logic [PROD_W-1:0]  prod_y_reg, sxy_reg;
    logic [SUM_W-1:0]   z_term, flat_sum;
    logic               valid_reg, inr_reg;
    logic [VOX_AW-1:0]  flat_reg;

    // Sizes above the volume act as the full volume.
    assign sx = (size_x > MAX_SIZE) ? MAX_SIZE : size_x;
    assign sy = (size_y > MAX_SIZE) ? MAX_SIZE : size_y;
    assign sz = (size_z > MAX_SIZE) ? MAX_SIZE : size_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            v1_reg    <= start;
            valid_reg <= v1_reg;
        end
    end

    // Stage one: row product and plane size.
    always_ff @(posedge aclk) begin
        if (start) begin
            inr1_reg   <= (pos_x < sx) && (pos_y < sy) && (pos_z < sz);
            px1_reg    <= pos_x;
            pz1_reg    <= pos_z;
            prod_y_reg <= PROD_W'(pos_y) * PROD_W'(sx);
            sxy_reg    <= PROD_W'(sx) * PROD_W'(sy);
        end
    end

    // Stage two: plane product and final sum.
    assign z_term   = SUM_W'(pz1_reg) * SUM_W'(sxy_reg);
    assign flat_sum = SUM_W'(px1_reg) + SUM_W'(prod_y_reg) + z_term;

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            inr_reg  <= inr1_reg;
            flat_reg <= flat_sum[VOX_AW-1:0];
        end
    end

    assign rsp.valid   = valid_reg;
    assign rsp.inrange = inr_reg;
    assign rsp.flat    = flat_reg;

endmodule

// ----- src/pvs_palette.sv -----
// Color palette memory with a sequential color search and append.
// Depends on pvs_pkg.
`timescale 1ns / 1ps

module pvs_palette (
    input  logic              aclk,
    input  logic              aresetn,
    input  pvs_pkg::pal_cmd_t cmd,
    output pvs_pkg::pal_rsp_t rsp
);
    import pvs_pkg::*;

    localparam logic [PAL_CW-1:0] DEPTH_C = PAL_CW'(PALETTE_DEPTH);

    logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];

    logic [PAL_CW-1:0]  used_reg, used_next;
    logic               busy_reg, busy_next;
    logic [PAL_CW-1:0]  scan_k_reg, scan_k_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [PAL_AW-1:0]  cmp_k_reg, cmp_k_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               done_reg, done_next;
    logic               full_reg, full_next;
    logic [PAL_AW-1:0]  idx_reg, idx_next;
    logic [COLOR_W-1:0] rd_data_reg;
    logic               rd_en, wr_en, match;
    logic [PAL_AW-1:0]  rd_addr;

    // The entry read last cycle is compared while the next one is fetched.
    assign match = cmp_valid_reg && (rd_data_reg == color_reg);

    always_comb begin
        used_next      = used_reg;
        busy_next      = busy_reg;
        scan_k_next    = scan_k_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_k_next     = cmp_k_reg;
        color_next     = color_reg;
        done_next      = done_reg;
        full_next      = full_reg;
        idx_next       = idx_reg;
        rd_en          = 1'b0;
        rd_addr        = cmd.index;
        wr_en          = 1'b0;
        if (cmd.lookup) begin
            busy_next      = 1'b1;
            scan_k_next    = PAL_CW'(1);
            cmp_valid_next = 1'b0;
            color_next     = cmd.color;
            done_next      = 1'b0;
            full_next      = 1'b0;
        end else if (cmd.fetch) begin
            rd_en = 1'b1;
        end else if (busy_reg) begin
            cmp_valid_next = 1'b0;
            if (match) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                idx_next  = cmp_k_reg;
            end else if (scan_k_reg < used_reg) begin
                rd_en          = 1'b1;
                rd_addr        = scan_k_reg[PAL_AW-1:0];
                cmp_valid_next = 1'b1;
                cmp_k_next     = scan_k_reg[PAL_AW-1:0];
                scan_k_next    = scan_k_reg + PAL_CW'(1);
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (used_reg >= DEPTH_C) begin
                    full_next = 1'b1;
                end else begin
                    wr_en     = 1'b1;
                    idx_next  = used_reg[PAL_AW-1:0];
                    used_next = used_reg + PAL_CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= PAL_CW'(1);
            busy_reg      <= 1'b0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            full_reg      <= 1'b0;
        end else begin
            used_reg      <= used_next;
            busy_reg      <= busy_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
            full_reg      <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_k_reg <= scan_k_next;
        cmp_k_reg  <= cmp_k_next;
        color_reg  <= color_next;
        idx_reg    <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pal_mem[used_reg[PAL_AW-1:0]] <= color_reg;
        end
        if (rd_en) begin
            rd_data_reg <= pal_mem[rd_addr];
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.full  = full_reg;
    assign rsp.idx   = idx_reg;
    assign rsp.color = rd_data_reg;

endmodule

// ----- src/pvs_region.sv -----
// Dirty bounding box tracker with empty and full flags.
// Depends on pvs_pkg.
`timescale 1ns / 1ps

module pvs_region (
    input  logic             aclk,
    input  logic             aresetn,
    input  pvs_pkg::mark_t   mark,
    input  logic             size_change,
    input  logic             take,
    output pvs_pkg::region_t region
);
    import pvs_pkg::*;

    // An empty box with zero bounds, as after reset or a take.
    localparam region_t REGION_RESET = '{bounds: '0, full: 1'b0, empty: 1'b1};

    region_t region_reg, region_next;
    logic [2:0][DIM_W-1:0] coord;

    assign coord = {mark.z, mark.y, mark.x};

    always_comb begin
        region_next = region_reg;
        if (take) begin
            region_next = '0;
            region_next.empty = 1'b1;
        end else begin
            if (size_change) begin
                region_next.full  = 1'b1;
                region_next.empty = 1'b0;
            end
            if (mark.valid) begin
                for (int a = 0; a < 3; a++) begin
                    if (region_reg.empty) begin
                        region_next.bounds[2*a]   = coord[a];
                        region_next.bounds[2*a+1] = coord[a];
                    end else begin
                        if (coord[a] < region_reg.bounds[2*a]) begin
                            region_next.bounds[2*a] = coord[a];
                        end
                        if (coord[a] > region_reg.bounds[2*a+1]) begin
                            region_next.bounds[2*a+1] = coord[a];
                        end
                    end
                end
                region_next.empty = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_reg <= REGION_RESET;
        end else begin
            region_reg <= region_next;
        end
    end

    assign region = region_reg;

endmodule

// ----- src/palette_voxel_store_unit.sv -----
// Top level of the palette voxel store: voxel index memory, item sequencer, output register.
// Depends on pvs_pkg, pvs_addr_gen, pvs_palette and pvs_region.
`timescale 1ns / 1ps

// The block stores a 32x32x32 volume of 8-bit palette indices in one synchronous memory and a
// 256-entry ARGB palette in a second one, and handles one word at a time. After reset it sweeps
// the voxel memory to zero, one entry per cycle; s_axis_tready stays low during that pass
// while configuration writes are taken as usual. Each item then goes through an address
// pipeline (x + y*sx + z*sx*sy); a read or write in range then reads the voxel, and a write
// does a read-modify-write of the old index. A take-region item, an unused op code or an
// out-of-range coordinate gives its result without a voxel access; a read of a solid voxel
// also reads the palette after the voxel memory. A write of a visible color searches the
// palette memory one entry per cycle, and a new color is appended at the end of that search
// if the palette has room. The next word is accepted once the result sits in the output
// register, so a stalled m_axis side holds one result while the following item is worked
// on. The memories see only one item at a time, so no two accesses to the same entry
// overlap. A change of a size register marks the whole volume dirty; voxel contents are
// not remapped.

module palette_voxel_store_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input words.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pos_x[5:0], pos_y[11:6], pos_z[17:12], argb[49:18], zero fill[55:50].
    input  logic [pvs_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // op[1:0].
    input  logic [pvs_pkg::OP_W-1:0]       s_axis_tuser,
    // Result words.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_argb[31:0], solid_total[47:32], box_empty[48], box_full[49], box_min_x[54:50],
    // box_max_x[59:55], box_min_y[64:60], box_max_y[69:65], box_min_z[74:70], box_max_z[79:75].
    output logic [pvs_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // status[1:0].
    output logic [pvs_pkg::STAT_W-1:0]     m_axis_tuser,
    // Configuration writes.
    input  logic                           cfg_wr_en,
    input  logic [pvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pvs_pkg::SIZE_W-1:0]     cfg_wdata
);
    import pvs_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_ADDR   = 8'b0000_0100,
        S_VREAD  = 8'b0000_1000,
        S_VDATA  = 8'b0001_0000,
        S_PFETCH = 8'b0010_0000,
        S_PWAIT  = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Voxel index memory.
    logic [PAL_AW-1:0] vox_mem [VOX_DEPTH];
    logic [PAL_AW-1:0] vox_rdata_reg;
    logic              vox_rd_en, vox_wr_en;
    logic [VOX_AW-1:0] vox_wr_addr;
    logic [PAL_AW-1:0] vox_wr_data;

    logic [VOX_AW-1:0]  clr_addr_reg, clr_addr_next;
    logic [OP_W-1:0]    op_reg;
    logic [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [COLOR_W-1:0] argb_reg;
    logic [COLOR_W-1:0] res_argb_reg, res_argb_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [COUNT_W-1:0] solid_reg, solid_next;
    logic [SIZE_W-1:0]  size_x_reg, size_y_reg, size_z_reg;
    logic [SIZE_W-1:0]  size_x_next, size_y_next, size_z_next;
    logic               size_change;
    logic               m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [STAT_W-1:0]  m_user_reg;
    logic               out_load, take, accept, alpha_set;

    addr_rsp_t addr_rsp;
    pal_cmd_t  pal_cmd;
    pal_rsp_t  pal_rsp;
    mark_t     mark;
    region_t   region;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign alpha_set     = (argb_reg[COLOR_W-1 -: ALPHA_W] != '0);

    pvs_addr_gen u_addr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .pos_x   (s_axis_tdata[COORD_W-1:0]),
        .pos_y   (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .pos_z   (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
        .size_x  (size_x_reg),
        .size_y  (size_y_reg),
        .size_z  (size_z_reg),
        .rsp     (addr_rsp)
    );

    pvs_palette u_palette (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (pal_cmd),
        .rsp     (pal_rsp)
    );

    pvs_region u_region (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .mark        (mark),
        .size_change (size_change),
        .take        (take),
        .region      (region)
    );

    // Size registers: a write that changes a value marks the whole volume dirty.
    always_comb begin
        size_x_next = size_x_reg;
        size_y_next = size_y_reg;
        size_z_next = size_z_reg;
        size_change = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SIZE_X: begin
                    size_x_next = cfg_wdata;
                    size_change = (cfg_wdata != size_x_reg);
                end
                CFG_SIZE_Y: begin
                    size_y_next = cfg_wdata;
                    size_change = (cfg_wdata != size_y_reg);
                end
                CFG_SIZE_Z: begin
                    size_z_next = cfg_wdata;
                    size_change = (cfg_wdata != size_z_reg);
                end
                default: begin
                    size_change = 1'b0;
                end
            endcase
        end
    end

    // Item sequencer. Every memory access of one item is finished before the next is accepted.
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        res_argb_next = res_argb_reg;
        status_next   = status_reg;
        solid_next    = solid_reg;
        m_valid_next  = m_valid_reg;
        vox_rd_en     = 1'b0;
        vox_wr_en     = 1'b0;
        vox_wr_addr   = addr_rsp.flat;
        vox_wr_data   = '0;
        pal_cmd       = '0;
        pal_cmd.color = argb_reg;
        pal_cmd.index = vox_rdata_reg;
        mark.valid    = 1'b0;
        mark.x        = px_reg[DIM_W-1:0];
        mark.y        = py_reg[DIM_W-1:0];
        mark.z        = pz_reg[DIM_W-1:0];
        out_load      = 1'b0;
        take          = 1'b0;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                vox_wr_en     = 1'b1;
                vox_wr_addr   = clr_addr_reg;
                clr_addr_next = clr_addr_reg + VOX_AW'(1);
                if (clr_addr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    res_argb_next = '0;
                    status_next   = STAT_DONE;
                    state_next    = S_ADDR;
                end
            end
            S_ADDR: begin
                if (addr_rsp.valid) begin
                    if (op_reg == OP_READ || op_reg == OP_WRITE) begin
                        if (addr_rsp.inrange) begin
                            state_next = S_VREAD;
                        end else begin
                            status_next = STAT_RANGE;
                            state_next  = S_RESULT;
                        end
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_VREAD: begin
                vox_rd_en = 1'b1;
                // The palette search runs alongside the voxel read.
                pal_cmd.lookup = (op_reg == OP_WRITE) && alpha_set;
                state_next     = S_VDATA;
            end
            S_VDATA: begin
                if (op_reg == OP_READ) begin
                    if (vox_rdata_reg == '0) begin
                        state_next = S_RESULT;
                    end else begin
                        pal_cmd.fetch = 1'b1;
                        state_next    = S_PFETCH;
                    end
                end else if (!alpha_set) begin
                    if (vox_rdata_reg != '0) begin
                        vox_wr_en  = 1'b1;
                        solid_next = solid_reg - COUNT_W'(1);
                        mark.valid = 1'b1;
                    end
                    state_next = S_RESULT;
                end else begin
                    state_next = S_PWAIT;
                end
            end
            S_PFETCH: begin
                res_argb_next = pal_rsp.color;
                state_next    = S_RESULT;
            end
            S_PWAIT: begin
                if (pal_rsp.done) begin
                    if (pal_rsp.full) begin
                        status_next = STAT_FULL;
                    end else if (pal_rsp.idx != vox_rdata_reg) begin
                        vox_wr_en   = 1'b1;
                        vox_wr_data = pal_rsp.idx;
                        mark.valid  = 1'b1;
                        if (vox_rdata_reg == '0) begin
                            solid_next = solid_reg + COUNT_W'(1);
                        end
                    end
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                // The region is sampled before a take clears it at the same edge.
                if (!m_valid_reg || m_axis_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    take         = (op_reg == OP_TAKE);
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            solid_reg    <= '0;
            size_x_reg   <= SIZE_W'(SIZE_RESET);
            size_y_reg   <= SIZE_W'(SIZE_RESET);
            size_z_reg   <= SIZE_W'(SIZE_RESET);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            solid_reg    <= solid_next;
            size_x_reg   <= size_x_next;
            size_y_reg   <= size_y_next;
            size_z_reg   <= size_z_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_axis_tuser;
            px_reg   <= s_axis_tdata[COORD_W-1:0];
            py_reg   <= s_axis_tdata[2*COORD_W-1:COORD_W];
            pz_reg   <= s_axis_tdata[3*COORD_W-1:2*COORD_W];
            argb_reg <= s_axis_tdata[3*COORD_W+COLOR_W-1:3*COORD_W];
        end
        res_argb_reg <= res_argb_next;
        status_reg   <= status_next;
        if (out_load) begin
            m_data_reg <= {region.bounds, region.full, region.empty, solid_reg, res_argb_reg};
            m_user_reg <= status_reg;
        end
    end

    // Voxel memory: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (vox_wr_en) begin
            vox_mem[vox_wr_addr] <= vox_wr_data;
        end
        if (vox_rd_en) begin
            vox_rdata_reg <= vox_mem[addr_rsp.flat];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // The voxel memory is never read and written in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) !(vox_rd_en && vox_wr_en))
        else $error("voxel memory read and write collide");

    // The solid count moves only where the old voxel index is examined.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_VDATA && state_reg != S_PWAIT) |=> $stable(solid_reg))
        else $error("solid count changed outside a voxel update");

    // A new result appears only from the result state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_RESULT))
        else $error("result loaded outside the result state");

    // No item is taken during the clearing pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("activity during the clearing pass");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of palette_voxel_store_unit: directed and random read, write,
// take-region and unused-op words, each checked against a behavioral copy of the store.
// Depends on pvs_pkg and on the palette_voxel_store_unit RTL.
`timescale 1ns / 1ps

module tb;
    import pvs_pkg::*;

    // The op code that the package leaves unnamed, and the register index past the last size.
    localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Cycles without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT = 100000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 244;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COLOR_W-1:0] argb;
    } cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0]    read_argb;
        logic [STAT_W-1:0]     status;
        logic [COUNT_W-1:0]    solid;
        logic                  empty;
        logic                  full;
        logic [5:0][DIM_W-1:0] bounds;
    } result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [STAT_W-1:0]     m_axis_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [SIZE_W-1:0]     cfg_wdata = '0;

    palette_voxel_store_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------------------
    // Behavioral copy of the store. It is advanced once per accepted input word, in the
    // order of acceptance, and by configuration writes, which only happen while idle.
    // ------------------------------------------------------------------------------------
    bit [PAL_AW-1:0]       vox_idx [VOX_DEPTH];
    bit [COLOR_W-1:0]      pal_color [PALETTE_DEPTH];
    int                    pal_used = 1;
    bit [COUNT_W-1:0]      solid = '0;
    bit                    reg_empty = 1'b1;
    bit                    reg_full = 1'b0;
    bit [5:0][DIM_W-1:0]   reg_bounds = '0;
    bit [SIZE_W-1:0]       size_reg [3] = '{6'd32, 6'd32, 6'd32};

    // Expected result words, oldest first, and the words still to be offered.
    result_t results_due [$];
    cmd_t    pending_cmds [$];

    // Stimulus side: sizes in force for coordinate picking, and colors handed out so far.
    bit [SIZE_W-1:0]    gen_size [3] = '{6'd32, 6'd32, 6'd32};
    bit [COLOR_W-1:0]   color_pool [$];
    bit [SIZE_W-1:0]    size_plan [PHASES][3] = '{
        '{6'd4,  6'd4,  6'd4},
        '{6'd1,  6'd1,  6'd1},
        '{6'd8,  6'd2,  6'd3},
        '{6'd0,  6'd5,  6'd5},
        '{6'd63, 6'd40, 6'd33},
        '{6'd32, 6'd32, 6'd32},
        '{6'd2,  6'd7,  6'd1},
        '{6'd5,  6'd7,  6'd6}
    };
    string bound_names [6] = '{"box_min_x", "box_max_x", "box_min_y",
                               "box_max_y", "box_min_z", "box_max_z"};

    // Handshake bookkeeping shared by the driver, ready side, monitor and sequencing block.
    bit in_fire = 1'b0;
    int words_taken = 0;
    int results_seen = 0;
    int mismatches = 0;
    int quiet = 0;
    int gap_left = 0;
    int hold_left = 0;
    int holds_done = 0;
    int op_count [4] = '{0, 0, 0, 0};
    int range_count = 0;
    int drop_count = 0;
    int peak_solid = 0;

    function automatic int size_in_use(input bit [SIZE_W-1:0] s);
        return (s < MAX_DIM) ? int'(s) : MAX_DIM;
    endfunction

    // Grow the dirty box to take in one voxel; an empty box starts at that voxel.
    function automatic void mark_dirty(input bit [DIM_W-1:0] x, input bit [DIM_W-1:0] y,
                                       input bit [DIM_W-1:0] z);
        bit [DIM_W-1:0] c [3];
        int a;
        c[0] = x;
        c[1] = y;
        c[2] = z;
        for (a = 0; a < 3; a++) begin
            if (reg_empty) begin
                reg_bounds[2*a]   = c[a];
                reg_bounds[2*a+1] = c[a];
            end else begin
                if (c[a] < reg_bounds[2*a])   reg_bounds[2*a]   = c[a];
                if (c[a] > reg_bounds[2*a+1]) reg_bounds[2*a+1] = c[a];
            end
        end
        reg_empty = 1'b0;
    endfunction

    // A size write that changes the register invalidates the whole volume's box.
    function automatic void note_size(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [SIZE_W-1:0] val);
        if (idx != CFG_SPARE && size_reg[idx] != val) begin
            size_reg[idx] = val;
            reg_full  = 1'b1;
            reg_empty = 1'b0;
        end
    endfunction

    // Apply one word to the store copy and return the result word it must produce.
    function automatic result_t compute_outcome(input cmd_t w);
        result_t     r;
        int          sx, sy, sz, flat, k;
        bit          inrange, found;
        bit [PAL_AW-1:0] old_idx, new_idx;
        r  = '0;
        sx = size_in_use(size_reg[CFG_SIZE_X]);
        sy = size_in_use(size_reg[CFG_SIZE_Y]);
        sz = size_in_use(size_reg[CFG_SIZE_Z]);
        inrange = (w.x < sx) && (w.y < sy) && (w.z < sz);
        flat = inrange ? (w.x + w.y * sx + w.z * sx * sy) : 0;
        case (w.op)
            OP_READ: begin
                if (!inrange) r.status = STAT_RANGE;
                else r.read_argb = pal_color[vox_idx[flat]];
            end
            OP_WRITE: begin
                if (!inrange) begin
                    r.status = STAT_RANGE;
                end else begin
                    old_idx = vox_idx[flat];
                    if (w.argb[COLOR_W-1 -: ALPHA_W] == '0) begin
                        // Transparent write clears the voxel if it holds anything.
                        if (old_idx != '0) begin
                            vox_idx[flat] = '0;
                            solid = solid - 1'b1;
                            mark_dirty(w.x[DIM_W-1:0], w.y[DIM_W-1:0], w.z[DIM_W-1:0]);
                        end
                    end else begin
                        found   = 1'b0;
                        new_idx = '0;
                        for (k = 1; k < pal_used && !found; k++) begin
                            if (pal_color[k] == w.argb) begin
                                new_idx = PAL_AW'(k);
                                found   = 1'b1;
                            end
                        end
                        if (!found) begin
                            if (pal_used >= PALETTE_DEPTH) begin
                                r.status = STAT_FULL;
                            end else begin
                                pal_color[pal_used] = w.argb;
                                new_idx  = PAL_AW'(pal_used);
                                pal_used = pal_used + 1;
                            end
                        end
                        if (r.status == STAT_DONE && new_idx != old_idx) begin
                            vox_idx[flat] = new_idx;
                            if (old_idx == '0) solid = solid + 1'b1;
                            mark_dirty(w.x[DIM_W-1:0], w.y[DIM_W-1:0], w.z[DIM_W-1:0]);
                        end
                    end
                end
            end
            default: ;
        endcase
        r.solid  = solid;
        r.empty  = reg_empty;
        r.full   = reg_full;
        r.bounds = reg_bounds;
        // A take reports the box as it stood, then starts a fresh one.
        if (w.op == OP_TAKE) begin
            reg_empty  = 1'b1;
            reg_full   = 1'b0;
            reg_bounds = '0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------------------
    // Idling. For one stretch of 160 words out of every 800 the sender adds no gaps and
    // the receiver is ready unless a hold runs; otherwise gaps are random and most are none.
    // ------------------------------------------------------------------------------------
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((words_taken / 160) % 5 == 2) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: offers one word at a time from pending_cmds. A word stays on the bus until the
    // monitor saw it taken; unless a gap is due, the next word replaces it at the same edge.
    always @(negedge aclk) begin
        cmd_t nxt;
        bit   drive;
        if (aresetn) begin
            drive = s_axis_tvalid && !in_fire;
            if (!drive) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_cmds.size() > 0) begin
                    nxt = pending_cmds.pop_front();
                    s_axis_tdata <= {6'b0, nxt.argb, nxt.z, nxt.y, nxt.x};
                    s_axis_tuser <= nxt.op;
                    drive    = 1'b1;
                    gap_left = draw_gap();
                end
            end
            s_axis_tvalid <= drive;
        end
    end

    // Result side ready. Twice the receiver holds off for a LONG_HOLD stretch while
    // the sender keeps offering, so the block's output register fills and its input stalls.
    always @(negedge aclk) begin
        bit rdy;
        int r;
        if (aresetn) begin
            r = $urandom_range(0, 99);
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if ((holds_done == 0 && results_seen >= 330) ||
                         (holds_done == 1 && results_seen >= 1400)) begin
                hold_left = LONG_HOLD - 1;
                holds_done++;
                rdy = 1'b0;
            end else if ((results_seen / 160) % 5 == 2 || r < 60) begin
                rdy = 1'b1;
            end else begin
                rdy = 1'b0;
                hold_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(15, 60);
            end
            m_axis_tready <= rdy;
        end
    end

    // Monitor: at each rising edge, checks a delivered result word against the oldest
    // expectation, then predicts the result of an input word taken at the same edge. The
    // block loads a result before taking the next word, so the two never belong together.
    always @(posedge aclk) begin
        result_t got, want;
        cmd_t    seen;
        int      i;
        if (aresetn) begin
            in_fire = s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got.read_argb = m_axis_tdata[31:0];
                got.solid     = m_axis_tdata[47:32];
                got.empty     = m_axis_tdata[48];
                got.full      = m_axis_tdata[49];
                for (i = 0; i < 6; i++) got.bounds[i] = m_axis_tdata[50 + 5*i +: 5];
                got.status    = m_axis_tuser;
                if (results_due.size() == 0) begin
                    $error("result word arrived with no word outstanding");
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("read_argb", want.read_argb, got.read_argb);
                    check_field("status", want.status, got.status);
                    check_field("solid_total", want.solid, got.solid);
                    check_field("box_empty", want.empty, got.empty);
                    check_field("box_full", want.full, got.full);
                    for (i = 0; i < 6; i++)
                        check_field(bound_names[i], want.bounds[i], got.bounds[i]);
                end
            end
            if (in_fire) begin
                seen.x    = s_axis_tdata[5:0];
                seen.y    = s_axis_tdata[11:6];
                seen.z    = s_axis_tdata[17:12];
                seen.argb = s_axis_tdata[49:18];
                seen.op   = s_axis_tuser;
                want = compute_outcome(seen);
                results_due.push_back(want);
                words_taken++;
                op_count[seen.op]++;
                if (want.status == STAT_RANGE) range_count++;
                if (want.status == STAT_FULL)  drop_count++;
                if (want.solid > peak_solid)   peak_solid = want.solid;
            end
            if (in_fire || (m_axis_tvalid && m_axis_tready)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet, results_due.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------------------
    task automatic push_cmd(input logic [OP_W-1:0] op, input int x, input int y, input int z,
                            input logic [COLOR_W-1:0] argb);
        cmd_t c;
        c.op   = op;
        c.x    = COORD_W'(x);
        c.y    = COORD_W'(y);
        c.z    = COORD_W'(z);
        c.argb = argb;
        pending_cmds.push_back(c);
    endtask

    // Configuration writes land at a falling edge and take effect at the next rising one.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        note_size(idx, val);
        if (idx != CFG_SPARE) gen_size[idx] = val;
    endtask

    task automatic cfg_done();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold further stimulus until every word is taken and every result has come back.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_axis_tvalid || results_due.size() != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // Mostly in range, with a bias toward a small corner so voxels get rewritten and read
    // back even in the large volumes; the rest spans the whole 6-bit field.
    function automatic int pick_coord(input bit [SIZE_W-1:0] s);
        int lim, r;
        lim = size_in_use(s);
        r   = $urandom_range(0, 99);
        if (lim == 0 || r < 12) return $urandom_range(0, 63);
        if (r < 50) return $urandom_range(0, ((lim < 4) ? lim : 4) - 1);
        return $urandom_range(0, lim - 1);
    endfunction

    // About half the visible colors are new, which fills the palette partway through the
    // run; the rest reuse earlier colors. Some writes are transparent clears.
    function automatic logic [COLOR_W-1:0] pick_color();
        int r;
        logic [COLOR_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 18) return {8'h00, 24'($urandom)};
        if (color_pool.size() == 0 || r < 60) begin
            c = $urandom;
            color_pool.push_back(c);
            return c;
        end
        return color_pool[$urandom_range(0, color_pool.size() - 1)];
    endfunction

    task automatic fill_random(input int count);
        int n, r;
        logic [OP_W-1:0] op;
        for (n = 0; n < count; n++) begin
            r  = $urandom_range(0, 99);
            op = (r < 35) ? OP_READ : (r < 82) ? OP_WRITE : (r < 94) ? OP_TAKE : OP_UNUSED;
            push_cmd(op, pick_coord(gen_size[CFG_SIZE_X]), pick_coord(gen_size[CFG_SIZE_Y]),
                     pick_coord(gen_size[CFG_SIZE_Z]),
                     (op == OP_WRITE) ? pick_color() : COLOR_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Sequencing: reset, a directed pass at the reset sizes, then one random phase per size
    // setting. Sizes change only once the block has drained, which also gives the sender's
    // pause until every expected result has come.
    // ------------------------------------------------------------------------------------
    initial begin
        int p;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words on the full 32x32x32 volume.
        push_cmd(OP_READ,   0,  0,  0, 32'h0000_0000);   // empty voxel reads as zero
        push_cmd(OP_WRITE,  0,  0,  0, 32'hFFFF_FFFF);   // first palette entry
        push_cmd(OP_READ,   0,  0,  0, 32'h0000_0000);
        push_cmd(OP_WRITE, 31, 31, 31, 32'h0100_0000);   // lowest visible alpha, far corner
        push_cmd(OP_WRITE,  0,  0,  0, 32'hFFFF_FFFF);   // same color again changes nothing
        push_cmd(OP_READ,  31, 31, 31, 32'hFFFF_FFFF);
        push_cmd(OP_WRITE, 32,  0,  0, 32'h1234_5678);   // x just past the edge
        push_cmd(OP_READ,   0, 63,  0, 32'h0000_0000);   // y at the field maximum
        push_cmd(OP_WRITE,  5,  5, 63, 32'hFFFF_FFFF);   // z at the field maximum
        push_cmd(OP_TAKE,  63, 63, 63, 32'hFFFF_FFFF);   // take ignores its operands
        push_cmd(OP_TAKE,   0,  0,  0, 32'h0000_0000);   // take of an empty box
        push_cmd(OP_WRITE, 31,  0, 31, 32'h00FF_FFFF);   // clearing an empty voxel
        push_cmd(OP_WRITE,  0,  0,  0, 32'h00AB_CDEF);   // clearing a solid voxel
        push_cmd(OP_READ,   0,  0,  0, 32'h0000_0000);
        push_cmd(OP_UNUSED, 63, 63, 63, 32'hFFFF_FFFF);  // unused op leaves state alone
        push_cmd(OP_WRITE,  1,  2,  3, 32'h80FF_00FF);
        push_cmd(OP_WRITE,  1,  2,  3, 32'h0100_0000);   // recolor with an existing entry
        push_cmd(OP_TAKE,   0,  0,  0, 32'h0000_0000);
        push_cmd(OP_READ,  31, 31, 31, 32'h0000_0000);
        push_cmd(OP_WRITE, 63, 63, 63, 32'hFFFF_FFFF);
        push_cmd(OP_READ,   1,  2,  3, 32'h0000_0000);
        push_cmd(OP_WRITE,  0, 31,  0, 32'hFFFF_FFFF);
        push_cmd(OP_TAKE,   0,  0,  0, 32'h0000_0000);
        color_pool.push_back(32'hFFFF_FFFF);
        color_pool.push_back(32'h0100_0000);
        color_pool.push_back(32'h80FF_00FF);
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            cfg_write(CFG_SIZE_X, size_plan[p][0]);
            cfg_write(CFG_SIZE_Y, size_plan[p][1]);
            cfg_write(CFG_SIZE_Z, size_plan[p][2]);
            // The spare index must be ignored by the block.
            if (p == 1) cfg_write(CFG_SPARE, 6'd17);
            cfg_done();
            fill_random(PHASE_WORDS);
            wait_drained();
        end

        // Let any stray result word surface before the verdict.
        repeat (40) @(negedge aclk);
        $display("Covered %0d words: %0d reads, %0d writes, %0d region takes, %0d unused ops,",
                 words_taken, op_count[OP_READ], op_count[OP_WRITE], op_count[OP_TAKE],
                 op_count[OP_UNUSED]);
        $display("%0d out of range, %0d dropped on a full palette, %0d palette entries, "
                 , range_count, drop_count, pal_used,
                 "peak of %0d solid voxels, %0d size settings.", peak_solid, PHASES + 1);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
